// File: rtl/pwfr_pkg.sv
`default_nettype none

package pwfr_pkg;

  // Input item kinds.
  localparam logic [1:0] MODE_LINE  = 2'd0;
  localparam logic [1:0] MODE_CHECK = 2'd1;
  localparam logic [1:0] MODE_POP   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ONE_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GAP_TIMEOUT   = 2'd1;

  // Register reset values.
  localparam logic [15:0] ONE_THRESHOLD_RESET = 16'd400;
  localparam logic [15:0] GAP_TIMEOUT_RESET   = 16'd3000;

  // Frame shape.
  localparam logic [4:0] FRAME_BITS    = 5'd16;
  localparam logic [4:0] BIT_COUNT_MAX = 5'd17;

  typedef struct packed {
    logic [1:0]  mode;
    logic        line_level;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic        popped;
    logic [7:0]  opcode;
    logic [31:0] start_us;
    logic        stored;
  } out_item_t;

  // One queued frame.
  typedef struct packed {
    logic [7:0]  opcode;
    logic [31:0] start_us;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/pwfr_queue.sv
`default_nettype none

module pwfr_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  pwfr_pkg::entry_t  push_entry,
  input  wire               pop,
  output pwfr_pkg::entry_t  rd_entry,
  output logic              full,
  output logic              empty
);
  import pwfr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  entry_t         mem [QUEUE_DEPTH];
  logic [AW-1:0]  write_pointer;
  logic [AW-1:0]  read_pointer;
  logic [AW-1:0]  write_pointer_next;
  logic [AW-1:0]  read_pointer_next;

  // Pointers wrap at the queue depth, which need not be a power of two.
  always_comb begin
    write_pointer_next = (write_pointer == AW'(QUEUE_DEPTH - 1)) ? '0 : write_pointer + 1'b1;
    read_pointer_next  = (read_pointer == AW'(QUEUE_DEPTH - 1)) ? '0 : read_pointer + 1'b1;
  end

  // One slot stays free so that full and empty differ.
  assign full  = (write_pointer_next == read_pointer);
  assign empty = (write_pointer == read_pointer);

  // Storage with a registered read port.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[write_pointer] <= push_entry;
    end
    if (pop) begin
      rd_entry <= mem[read_pointer];
    end
  end

  // Pointer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
    end else begin
      if (push) begin
        write_pointer <= write_pointer_next;
      end
      if (pop) begin
        read_pointer <= read_pointer_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/pulse_width_frame_receiver.sv
// An accepted item's flags go to the result stage and then, with the queue read
// data, to the output register, which holds the result until it transfers out.
// One item per cycle is taken while the output does not stall.
// A result stage and an output register let one more item in while a result waits.
// Reset (synchronous, active high) clears the receiver, the queue pointers and
// the pipeline, and restores the thresholds to 400 us and 3000 us.
`default_nettype none

module pulse_width_frame_receiver #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  pwfr_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  wire                   out_stall,
  output pwfr_pkg::out_item_t   out_item,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [1:0]             cfg_index,
  input  wire [15:0]            cfg_data
);
  import pwfr_pkg::*;

  // Configuration registers.
  logic [15:0] one_threshold_us;
  logic [15:0] gap_timeout_us;

  // Receiver state.
  logic [15:0] shift_bits;
  logic [4:0]  bit_count;
  logic [31:0] frame_first_fall;
  logic [31:0] last_fall_time;

  // Result stage and output register.
  logic        s1_valid;
  logic        s1_popped;
  logic        s1_stored;
  entry_t      rd_entry;

  logic        accept;
  logic        move;
  logic [31:0] elapsed;
  logic        long_pulse;
  logic        gap_over;
  logic        frame_ok;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  entry_t      push_entry;

  assign cfg_ready = 1'b1;

  assign accept   = in_valid && !in_stall;
  assign move     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  // Time since the last falling edge, modulo 2^32.
  assign elapsed    = in_item.now_us - last_fall_time;
  assign long_pulse = (elapsed >= {16'd0, one_threshold_us});
  assign gap_over   = (elapsed >= {16'd0, gap_timeout_us});

  // A complete frame has 16 bits and a low byte that complements the high byte.
  assign frame_ok = (bit_count == FRAME_BITS) && (shift_bits[15:8] == ~shift_bits[7:0]);

  assign q_push = accept && (in_item.mode == MODE_CHECK) && gap_over && frame_ok && !q_full;
  assign q_pop  = accept && (in_item.mode == MODE_POP) && !q_empty;

  assign push_entry.opcode   = shift_bits[15:8];
  assign push_entry.start_us = frame_first_fall;

  pwfr_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .rd_entry  (rd_entry),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      one_threshold_us <= ONE_THRESHOLD_RESET;
      gap_timeout_us   <= GAP_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ONE_THRESHOLD: one_threshold_us <= cfg_data;
        REG_GAP_TIMEOUT:   gap_timeout_us   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line decoding and frame clearing.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits       <= '0;
      bit_count        <= '0;
      frame_first_fall <= '0;
      last_fall_time   <= '0;
    end else if (accept) begin
      unique case (in_item.mode)
        MODE_LINE: begin
          if (in_item.line_level) begin
            shift_bits <= {shift_bits[14:0], long_pulse};
            if (bit_count < BIT_COUNT_MAX) begin
              bit_count <= bit_count + 5'd1;
            end
          end else begin
            last_fall_time <= in_item.now_us;
            if (bit_count == '0) begin
              frame_first_fall <= in_item.now_us;
            end
          end
        end
        MODE_CHECK: begin
          if (gap_over) begin
            shift_bits <= '0;
            bit_count  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result stage: holds the item's flags while the queue read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !move);
    end
    if (accept) begin
      s1_popped <= q_pop;
      s1_stored <= q_push;
    end
  end

  // Output register; fields without meaning are zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (move) begin
      out_item.popped   <= s1_popped;
      out_item.opcode   <= s1_popped ? rd_entry.opcode : 8'd0;
      out_item.start_us <= s1_popped ? rd_entry.start_us : 32'd0;
      out_item.stored   <= s1_stored;
    end
  end

endmodule

`default_nettype wire

// File: sim/pulse_width_frame_receiver_tb.sv
`default_nettype none

module pulse_width_frame_receiver_tb;
  import pwfr_pkg::*;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  // Mode code that the block must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Register indexes that do not exist.
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;
  // Result count at which the receiver holds off for a long stretch.
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pulse_width_frame_receiver #(
    .QUEUE_DEPTH(FIFO_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Decoder state mirrored by the testbench.
  logic [15:0] thr_us = ONE_THRESHOLD_RESET;
  logic [15:0] gap_us = GAP_TIMEOUT_RESET;
  logic [15:0] rx_bits = '0;
  logic [4:0]  rx_count = '0;
  logic [31:0] rx_start = '0;
  logic [31:0] rx_last_fall = '0;
  entry_t      fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] fifo_wr = '0;
  logic [PTR_W-1:0] fifo_rd = '0;

  in_item_t  event_queue[$];
  out_item_t decoder_answers[$];

  // Stimulus shaping.
  logic [31:0] gen_time = 32'h0001_0000;
  logic [31:0] gen_last_fall = '0;
  int          gen_items = 0;
  logic        steady = 1'b0;
  logic        no_pops = 1'b0;

  // Run statistics.
  int errors = 0;
  int accepted = 0;
  int results_checked = 0;
  int frames_queued = 0;
  int frames_refused = 0;
  int entries_popped = 0;
  int hold_left = 0;
  logic held = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one input event to the mirrored decoder and return its result.
  function automatic out_item_t decode_event(in_item_t ev);
    out_item_t res;
    logic [31:0] elapsed;
    logic [PTR_W-1:0] nxt;
    res = '0;
    elapsed = ev.now_us - rx_last_fall;
    case (ev.mode)
      MODE_LINE: begin
        if (ev.line_level) begin
          rx_bits = {rx_bits[14:0], (elapsed >= {16'd0, thr_us})};
          if (rx_count < BIT_COUNT_MAX) rx_count = rx_count + 1'b1;
        end else begin
          rx_last_fall = ev.now_us;
          if (rx_count == '0) rx_start = ev.now_us;
        end
      end
      MODE_CHECK: begin
        if (elapsed >= {16'd0, gap_us}) begin
          nxt = fifo_wr + 1'b1;
          if (rx_count == FRAME_BITS && rx_bits[15:8] == ~rx_bits[7:0]) begin
            if (nxt != fifo_rd) begin
              fifo_mem[fifo_wr].opcode = rx_bits[15:8];
              fifo_mem[fifo_wr].start_us = rx_start;
              fifo_wr = nxt;
              res.stored = 1'b1;
              frames_queued++;
            end else begin
              frames_refused++;
            end
          end
          rx_bits = '0;
          rx_count = '0;
        end
      end
      MODE_POP: begin
        if (fifo_rd != fifo_wr) begin
          res.popped = 1'b1;
          res.opcode = fifo_mem[fifo_rd].opcode;
          res.start_us = fifo_mem[fifo_rd].start_us;
          fifo_rd = fifo_rd + 1'b1;
          entries_popped++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic add_item(input logic [1:0] mode, input logic lvl, input logic [31:0] now);
    in_item_t ev;
    ev.mode = mode;
    ev.line_level = lvl;
    ev.now_us = now;
    event_queue.push_back(ev);
    gen_items++;
  endtask

  // Queue the edges of one frame, most significant bit first, with a few
  // early checks and pops mixed in.
  task automatic add_frame(input logic [19:0] bits, input int nbits);
    int unsigned w;
    for (int i = nbits - 1; i >= 0; i--) begin
      gen_time = gen_time + $urandom_range(300, 20);
      add_item(MODE_LINE, 1'b0, gen_time);
      gen_last_fall = gen_time;
      if (gap_us != 0 && $urandom_range(99) < 5)
        add_item(MODE_CHECK, 1'($urandom_range(1)),
                 gen_last_fall + $urandom_range(gap_us - 1));
      if (!no_pops && $urandom_range(99) < 3)
        add_item(MODE_POP, 1'($urandom_range(1)), $urandom);
      if (bits[i]) w = thr_us + $urandom_range(300);
      else if (thr_us == 0) w = 0;
      else w = $urandom_range(thr_us - 1);
      gen_time = gen_time + w;
      add_item(MODE_LINE, 1'b1, gen_time);
    end
  endtask

  // Check that lands after the gap has run out.
  task automatic end_check();
    int unsigned t;
    t = $urandom_range(200);
    add_item(MODE_CHECK, 1'($urandom_range(1)), gen_last_fall + gap_us + t);
    gen_time = gen_time + gap_us + t + 1;
  endtask

  // Mostly well-formed frames, the rest broken frames, pops and noise.
  task automatic run_random(input int count);
    int first;
    int r;
    logic [7:0] hi;
    logic [19:0] bits;
    logic [1:0] m;
    logic lvl;
    logic [31:0] t;
    first = gen_items;
    while (gen_items - first < count) begin
      r = $urandom_range(99);
      if (r < 55) begin
        hi = 8'($urandom);
        add_frame({4'h0, hi, ~hi}, 16);
        end_check();
      end else if (r < 65) begin
        bits = 20'($urandom);
        add_frame(bits, $urandom_range(20));
        if ($urandom_range(9) != 0) end_check();
      end else if (r < 73) begin
        hi = 8'($urandom);
        add_frame({4'h0, hi, ~hi ^ (8'h01 << $urandom_range(7))}, 16);
        end_check();
      end else if (r < 90) begin
        repeat ($urandom_range(3, 1)) add_item(MODE_POP, 1'($urandom_range(1)), $urandom);
      end else begin
        m = 2'($urandom_range(3));
        lvl = 1'($urandom_range(1));
        t = $urandom_range(1) ? $urandom : gen_time + $urandom_range(5000);
        add_item(m, lvl, t);
        if (m == MODE_LINE && !lvl) gen_last_fall = t;
      end
    end
  endtask

  // Wait until every queued event has gone in and every result has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (event_queue.size() != 0 || in_valid || decoder_answers.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ONE_THRESHOLD) thr_us = val;
    else if (idx == REG_GAP_TIMEOUT) gap_us = val;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Sender: offer queued events, predicting each one as it transfers.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        decoder_answers.push_back(decode_event(in_item));
        accepted++;
      end
      if (event_queue.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
        in_item <= event_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each result transfer and choose the next stall.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoder_answers.size() == 0) begin
          $error("result with nothing awaited: %h", out_item);
          errors++;
        end else begin
          want = decoder_answers.pop_front();
          compare_field("popped", 32'(want.popped), 32'(out_item.popped));
          compare_field("opcode", 32'(want.opcode), 32'(out_item.opcode));
          compare_field("start_us", want.start_us, out_item.start_us);
          compare_field("stored", 32'(want.stored), 32'(out_item.stored));
          results_checked++;
        end
      end
      // One long hold-off lets the block fill up and stall its input.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && results_checked >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 10);
      end
    end
  end

  // Main sequence of phases.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed events at the reset settings.
    add_item(MODE_POP, 1'b0, 32'h0000_0000);
    add_item(MODE_UNUSED, 1'b1, 32'hFFFF_FFFF);
    add_item(MODE_UNUSED, 1'b0, 32'h0000_0000);
    add_item(MODE_CHECK, 1'b0, 32'h0000_0000);
    add_item(MODE_CHECK, 1'b1, 32'd2999);
    add_item(MODE_CHECK, 1'b0, 32'd3000);
    // Pulse that wraps the timestamp, one short of the threshold.
    add_item(MODE_LINE, 1'b0, 32'hFFFF_FF00);
    add_item(MODE_LINE, 1'b1, 32'hFFFF_FF00 + 32'd399);
    // Pulse exactly at the threshold, then a rise with no fall before it.
    add_item(MODE_LINE, 1'b0, 32'h0000_0100);
    add_item(MODE_LINE, 1'b1, 32'h0000_0100 + 32'd400);
    add_item(MODE_LINE, 1'b1, 32'hFFFF_FFFF);
    // Short frame: the gap one short, then exactly reached.
    add_item(MODE_CHECK, 1'b1, 32'h0000_0100 + 32'd2999);
    add_item(MODE_CHECK, 1'b0, 32'h0000_0100 + 32'd3000);
    add_item(MODE_POP, 1'b1, 32'hFFFF_FFFF);
    gen_last_fall = 32'h0000_0100;
    run_random(100);
    wait_idle();

    // Both registers at zero.
    write_reg(REG_ONE_THRESHOLD, 16'd0);
    write_reg(REG_GAP_TIMEOUT, 16'd0);
    run_random(60);
    wait_idle();

    // Both registers at their maximum; writes to absent registers change nothing.
    write_reg(REG_ONE_THRESHOLD, 16'hFFFF);
    write_reg(REG_GAP_TIMEOUT, 16'hFFFF);
    write_reg(REG_SPARE_LO, 16'h5A5A);
    write_reg(REG_SPARE_HI, 16'h0000);
    run_random(80);
    wait_idle();

    // Moderate settings with no idling on either side.
    write_reg(REG_ONE_THRESHOLD, 16'($urandom_range(2000, 100)));
    write_reg(REG_GAP_TIMEOUT, 16'($urandom_range(20000, 6000)));
    steady = 1'b1;
    run_random(120);
    wait_idle();
    steady = 1'b0;

    // Queue a few frames with no pops, then drain the entry queue past empty.
    write_reg(REG_ONE_THRESHOLD, ONE_THRESHOLD_RESET);
    write_reg(REG_GAP_TIMEOUT, GAP_TIMEOUT_RESET);
    no_pops = 1'b1;
    repeat (4) begin
      logic [7:0] hi;
      hi = 8'($urandom);
      add_frame({4'h0, hi, ~hi}, 16);
      end_check();
    end
    repeat (10) add_item(MODE_POP, 1'($urandom_range(1)), $urandom);
    no_pops = 1'b0;
    wait_idle();

    // Fully random settings.
    write_reg(REG_ONE_THRESHOLD, 16'($urandom_range(65535)));
    write_reg(REG_GAP_TIMEOUT, 16'($urandom_range(65535)));
    run_random(150);
    wait_idle();

    repeat (10) @(negedge clk);
    $display("Checked %0d results over %0d transfers in six register settings.",
             results_checked, accepted);
    $display("Frames queued %0d, refused by a full queue %0d, entries popped %0d.",
             frames_queued, frames_refused, entries_popped);
    if (errors == 0 && decoder_answers.size() == 0) begin
      $display("** pulse_width_frame_receiver: PASSED **");
    end else begin
      $display("** pulse_width_frame_receiver: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(8 * 200000);
    $display("Timeout with %0d results still awaited.", decoder_answers.size());
    $display("** pulse_width_frame_receiver: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
